// ===== src/multi_channel_phase_fire_scheduler_top_macros.svh =====
// Assertion macros for the phase fire scheduler checker.
// Used by mcpfs_chk; the checker must provide clk and rst.
`ifndef MULTI_CHANNEL_PHASE_FIRE_SCHEDULER_TOP_MACROS_SVH
`define MULTI_CHANNEL_PHASE_FIRE_SCHEDULER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MCPFS_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MCPFS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/mcpfs_pkg.sv =====
// Shared types and constants for the phase fire scheduler.
// No dependencies; every other file but the macro header imports this package.
package mcpfs_pkg;

  localparam int DELAY_W        = 16;
  localparam int DZ_W           = 15;
  localparam int TIMER_W        = 17;
  localparam int OUT_W          = 4;
  localparam int NUM_DELAY_REGS = 4;
  localparam int CFG_IDX_W      = 4;
  localparam int DEF_CHANNELS   = 4;
  localparam int DEF_MIN_DELAY  = 90;

  localparam logic [DELAY_W-1:0]        OFF_VALUE     = 16'hFFFF;
  localparam logic signed [TIMER_W-1:0] TIMER_CEILING = 17'sd65534;

  // Action codes of an input item.
  localparam logic ACT_ZERO_CROSS = 1'b1;

  typedef struct packed {
    logic            action;
    logic [DZ_W-1:0] delay_until_zero;
  } evt_item_t;

  typedef struct packed {
    logic [OUT_W-1:0] gate_levels;
    logic [OUT_W-1:0] fired_now;
  } res_item_t;

  // Commands from the top level to the channel scanner.
  typedef struct packed {
    logic            start;
    logic            zero_cross;
    logic [DZ_W-1:0] dz;
    logic            take;
  } scan_ctl_t;

  // Status from the channel scanner.
  typedef struct packed {
    logic busy;
    logic done;
  } scan_sts_t;

endpackage

// ===== src/mcpfs_cfg.sv =====
// Delay register file of the phase fire scheduler.
// Depends on mcpfs_pkg; read one channel at a time by the scanner.
module mcpfs_cfg #(
  parameter int CHANNELS = mcpfs_pkg::DEF_CHANNELS,
  parameter int CH_W     = 2
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [mcpfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcpfs_pkg::DELAY_W-1:0]   cfg_data,
  input  logic [CH_W-1:0]                 rd_ch,
  output logic [mcpfs_pkg::DELAY_W-1:0]   rd_delay
);
  import mcpfs_pkg::*;

  localparam int REGS = (CHANNELS < NUM_DELAY_REGS) ? CHANNELS : NUM_DELAY_REGS;
  localparam int RW   = (REGS > 1) ? $clog2(REGS) : 1;

  logic [DELAY_W-1:0] delay [REGS];
  logic               wr_hit;
  logic               rd_hit;

  assign wr_hit = cfg_we && (cfg_index < CFG_IDX_W'(REGS));
  assign rd_hit = {1'b0, rd_ch} < (CH_W+1)'(REGS);

  // Registers written by index; writes beyond the implemented set are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < REGS; i++) begin
        delay[i] <= OFF_VALUE;
      end
    end else if (wr_hit) begin
      delay[cfg_index[RW-1:0]] <= cfg_data;
    end
  end

  // Channels without a register are permanently off.
  always_comb begin
    if (rd_hit) begin
      rd_delay = delay[rd_ch[RW-1:0]];
    end else begin
      rd_delay = OFF_VALUE;
    end
  end

endmodule

// ===== src/mcpfs_scan.sv =====
// Channel scanner: timer, alarm times, gate state and one shared comparator
// stepped over the channels by a small sequencer. Depends on mcpfs_pkg.
module mcpfs_scan #(
  parameter int CHANNELS  = mcpfs_pkg::DEF_CHANNELS,
  parameter int MIN_DELAY = mcpfs_pkg::DEF_MIN_DELAY,
  parameter int CH_W      = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mcpfs_pkg::scan_ctl_t         ctl,
  input  logic [mcpfs_pkg::DELAY_W-1:0] rd_delay,
  output logic [CH_W-1:0]              rd_ch,
  output mcpfs_pkg::scan_sts_t         sts,
  output logic [CHANNELS-1:0]          gate,
  output logic [CHANNELS-1:0]          fired
);
  import mcpfs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [CH_W-1:0]    LAST_CH = CH_W'(CHANNELS - 1);
  localparam logic [DELAY_W-1:0] MIN_DLY = DELAY_W'(MIN_DELAY);

  logic [1:0]         state;
  logic [CH_W-1:0]    ch;
  logic               zc;
  logic [TIMER_W-1:0] timer;
  logic [DELAY_W-1:0] alarm [CHANNELS];

  logic [DELAY_W-1:0] op_a;
  logic [DELAY_W-1:0] op_b;
  logic               cmp_lt;
  logic               tick_fire;

  assign rd_ch    = ch;
  assign sts.busy = (state != ST_IDLE);
  assign sts.done = (state == ST_DONE);

  // Shared comparator: delay against the minimum on a zero cross,
  // timer against the alarm time on a tick.
  always_comb begin
    if (zc) begin
      op_a = rd_delay;
      op_b = MIN_DLY;
    end else begin
      op_a = timer[DELAY_W-1:0];
      op_b = alarm[ch];
    end
  end

  assign cmp_lt    = op_a < op_b;
  assign tick_fire = !timer[TIMER_W-1] && (alarm[ch] != OFF_VALUE) && !cmp_lt;

  // Sequencer: one channel per cycle, then hold the result for hand-off.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ch    <= '0;
      zc    <= 1'b0;
      timer <= '0;
      gate  <= '0;
      fired <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        alarm[i] <= OFF_VALUE;
      end
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ctl.start) begin
            zc    <= ctl.zero_cross;
            ch    <= '0;
            fired <= '0;
            state <= ST_RUN;
            if (ctl.zero_cross) begin
              timer <= TIMER_W'(0) - {2'b00, ctl.dz};
            end else if ($signed(timer) < TIMER_CEILING) begin
              timer <= timer + TIMER_W'(1);
            end
          end
        end
        ST_RUN: begin
          if (zc) begin
            if (rd_delay == '0) begin
              gate[ch]  <= 1'b1;
              fired[ch] <= 1'b1;
              alarm[ch] <= OFF_VALUE;
            end else begin
              gate[ch]  <= 1'b0;
              alarm[ch] <= cmp_lt ? MIN_DLY : rd_delay;
            end
          end else if (tick_fire) begin
            gate[ch]  <= 1'b1;
            fired[ch] <= 1'b1;
            alarm[ch] <= OFF_VALUE;
          end
          if (ch == LAST_CH) begin
            state <= ST_DONE;
          end else begin
            ch <= ch + CH_W'(1);
          end
        end
        ST_DONE: begin
          if (ctl.take) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/multi_channel_phase_fire_scheduler_top.sv =====
// Phase fire scheduler: an item is accepted when idle; the scan then visits
// one channel per cycle through a single shared comparator, holds the result
// until the output register can take it, and only then accepts the next item.
// Synchronous reset: timer zero, all channels disarmed, gates low, delays 65535.
// Depends on mcpfs_pkg, mcpfs_cfg and mcpfs_scan.
module multi_channel_phase_fire_scheduler_top #(
  parameter int CHANNELS  = mcpfs_pkg::DEF_CHANNELS,
  parameter int MIN_DELAY = mcpfs_pkg::DEF_MIN_DELAY
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            evt_valid,
  output logic                            evt_stall,
  input  mcpfs_pkg::evt_item_t            evt,
  output logic                            res_valid,
  input  logic                            res_stall,
  output mcpfs_pkg::res_item_t            res,
  input  logic                            cfg_we,
  input  logic [mcpfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mcpfs_pkg::DELAY_W-1:0]   cfg_data
);
  import mcpfs_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  scan_ctl_t                    ctl;
  scan_sts_t                    sts;
  logic [CH_W-1:0]              rd_ch;
  logic [DELAY_W-1:0]           rd_delay;
  logic [CHANNELS-1:0]          gate;
  logic [CHANNELS-1:0]          fired;
  logic [CHANNELS+OUT_W-1:0]    gate_ext;
  logic [CHANNELS+OUT_W-1:0]    fired_ext;

  // Input side accepts only while the scanner is idle.
  assign evt_stall      = sts.busy;
  assign ctl.start      = evt_valid && !evt_stall;
  assign ctl.zero_cross = (evt.action == ACT_ZERO_CROSS);
  assign ctl.dz         = evt.delay_until_zero;
  assign ctl.take       = sts.done && (!res_valid || !res_stall);

  mcpfs_cfg #(
    .CHANNELS (CHANNELS),
    .CH_W     (CH_W)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rd_ch     (rd_ch),
    .rd_delay  (rd_delay)
  );

  mcpfs_scan #(
    .CHANNELS  (CHANNELS),
    .MIN_DELAY (MIN_DELAY),
    .CH_W      (CH_W)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .rd_delay (rd_delay),
    .rd_ch    (rd_ch),
    .sts      (sts),
    .gate     (gate),
    .fired    (fired)
  );

  // Only the low channels appear in the result; missing ones read as zero.
  assign gate_ext  = {OUT_W'(0), gate};
  assign fired_ext = {OUT_W'(0), fired};

  // Output register parts the result from the scanner.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (ctl.take) begin
      res_valid <= 1'b1;
    end else if (res_valid && !res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      res.gate_levels <= gate_ext[OUT_W-1:0];
      res.fired_now   <= fired_ext[OUT_W-1:0];
    end
  end

endmodule

// ===== src/mcpfs_chk.sv =====
// Port-level checker for the phase fire scheduler, bound to the top level.
// Depends on mcpfs_pkg and the assertion macro header.
`include "multi_channel_phase_fire_scheduler_top_macros.svh"

module mcpfs_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            evt_valid,
  input logic                            evt_stall,
  input logic                            res_valid,
  input logic                            res_stall,
  input mcpfs_pkg::res_item_t            res
);
  import mcpfs_pkg::*;

  // A stalled result stays put.
  `MCPFS_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(res), "result changed while stalled")

  // A channel turned on by an item must show its gate high.
  `MCPFS_ASSERT_NOW(a_fired_gate, res_valid, (res.fired_now & ~res.gate_levels) == '0, "fired channel with gate low")

  // Once an item is taken the block works on it before taking another.
  `MCPFS_ASSERT_NEXT(a_busy_after_accept, evt_valid && !evt_stall, evt_stall, "second item accepted while busy")

endmodule

bind multi_channel_phase_fire_scheduler_top mcpfs_chk u_chk (.*);

// ===== sim/tb_top.sv =====
// Self-checking testbench for the multi-channel phase fire scheduler.
// Needs only mcpfs_pkg and multi_channel_phase_fire_scheduler_top; a tracker
// class predicts gate levels and fired bits for every accepted item.
module tb_top;
  import mcpfs_pkg::*;

  localparam int CH          = DEF_CHANNELS;
  localparam int MIN_US      = DEF_MIN_DELAY;
  localparam int TIMER_MAX   = int'(TIMER_CEILING);
  localparam int RANDOM_ITEMS = 1690;
  localparam int DRAIN_CYCLES = CH + 4;
  localparam int CYCLE_LIMIT  = 3000000;

  localparam logic ACT_TICK = ~ACT_ZERO_CROSS;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_0 = 'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_1 = 'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_2 = 'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_3 = 'd3;

  // Tracks timer, alarms and gates, and holds the results still to come.
  class gate_fire_tracker;
    logic [DELAY_W-1:0] chan_delay [CH];
    logic [DELAY_W-1:0] alarm_us [CH];
    logic [CH-1:0]      gates;
    int                 timer_us;
    res_item_t          expected_gates_q [$];
    int                 mismatches;

    function new();
      for (int c = 0; c < CH; c++) begin
        chan_delay[c] = OFF_VALUE;
        alarm_us[c] = OFF_VALUE;
      end
      gates      = '0;
      timer_us   = 0;
      mismatches = 0;
    endfunction

    // Writes to indexes without a delay register are dropped.
    function void write_delay(int idx, logic [DELAY_W-1:0] value);
      if (idx < NUM_DELAY_REGS && idx < CH) chan_delay[idx] = value;
    endfunction

    // Works out the result of one accepted item.
    function void note_event(evt_item_t item);
      logic [CH-1:0] fired;
      res_item_t     want;
      fired = '0;
      if (item.action == ACT_ZERO_CROSS) begin
        timer_us = -int'(item.delay_until_zero);
        for (int c = 0; c < CH; c++) begin
          if (chan_delay[c] == '0) begin
            gates[c]    = 1'b1;
            fired[c]    = 1'b1;
            alarm_us[c] = OFF_VALUE;
          end else begin
            gates[c]    = 1'b0;
            alarm_us[c] = (int'(chan_delay[c]) < MIN_US) ? DELAY_W'(MIN_US) : chan_delay[c];
          end
        end
      end else begin
        if (timer_us < TIMER_MAX) timer_us++;
        if (timer_us >= 0) begin
          for (int c = 0; c < CH; c++) begin
            if (alarm_us[c] != OFF_VALUE && int'(alarm_us[c]) <= timer_us) begin
              gates[c]    = 1'b1;
              fired[c]    = 1'b1;
              alarm_us[c] = OFF_VALUE;
            end
          end
        end
      end
      want.gate_levels = OUT_W'(gates);
      want.fired_now   = OUT_W'(fired);
      expected_gates_q.push_back(want);
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_gates(res_item_t got);
      res_item_t want;
      if (expected_gates_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: unexpected result gate_levels=%h fired_now=%h",
                   $time, got.gate_levels, got.fired_now);
        return;
      end
      want = expected_gates_q.pop_front();
      if (got.gate_levels !== want.gate_levels || got.fired_now !== want.fired_now) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR %0t: gate_levels exp %h got %h, fired_now exp %h got %h",
                   $time, want.gate_levels, got.gate_levels, want.fired_now, got.fired_now);
      end
    endfunction

    function int pending();
      return expected_gates_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 evt_valid = 1'b0;
  logic                 evt_stall;
  evt_item_t            evt       = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_item_t            res;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DELAY_W-1:0]   cfg_data  = '0;

  gate_fire_tracker tracker;
  bit send_idle  = 1'b1;
  bit recv_idle  = 1'b1;
  int stall_left = 0;
  int items_sent = 0;
  int cycles     = 0;

  multi_channel_phase_fire_scheduler_top dut (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit in clock cycles.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    case ($urandom_range(0, 19))
      0, 1:    return '0;
      2, 3:    return DELAY_W'($urandom_range(1, MIN_US - 1));
      4:       return DELAY_W'(MIN_US);
      5:       return DELAY_W'(MIN_US - 1);
      6, 7:    return OFF_VALUE;
      8:       return DELAY_W'($urandom);
      9:       return OFF_VALUE - 1'b1;
      default: return DELAY_W'($urandom_range(MIN_US + 1, 300));
    endcase
  endfunction

  function automatic int pick_dz();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return $urandom_range(0, 40);
    if (r < 9) return $urandom_range(0, 300);
    return $urandom_range(0, 32767);
  endfunction

  // Ticks from a zero cross until all reachable channels fire (dz <= 2000).
  function automatic int ticks_to_fire(int dz);
    int latest;
    int d;
    latest = 0;
    if (dz > 2000) return $urandom_range(5, 60);
    for (int c = 0; c < CH; c++) begin
      d = int'(tracker.chan_delay[c]);
      if (d != int'(OFF_VALUE) && d <= 1000 && d > 0)
        latest = (d < MIN_US) ? ((MIN_US > latest) ? MIN_US : latest)
                              : ((d > latest) ? d : latest);
    end
    if (latest == 0) return $urandom_range(5, 40);
    return latest + dz;
  endfunction

  // Result side: check accepted items and stall at random.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) tracker.check_gates(res);
    if (stall_left > 0) begin
      res_stall <= 1'b1;
      stall_left--;
    end else begin
      res_stall <= 1'b0;
      if (recv_idle) stall_left = pick_gap();
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input evt_item_t item);
    int gap;
    gap = send_idle ? pick_gap() : 0;
    if (gap > 0) begin
      evt_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    evt       <= item;
    evt_valid <= 1'b1;
    @(posedge clk);
    while (evt_stall) @(posedge clk);
    tracker.note_event(item);
    items_sent++;
  endtask

  task automatic send_tick();
    evt_item_t item;
    item.action           = ACT_TICK;
    item.delay_until_zero = DZ_W'($urandom);
    send_item(item);
  endtask

  task automatic send_zero_cross(input int dz);
    evt_item_t item;
    item.action           = ACT_ZERO_CROSS;
    item.delay_until_zero = DZ_W'(dz);
    send_item(item);
  endtask

  task automatic send_ticks(input int n);
    for (int k = 0; k < n; k++) send_tick();
  endtask

  // Stops sending and lets every expected result drain out.
  task automatic wait_idle();
    evt_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DELAY_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    tracker.write_delay(int'(idx), value);
  endtask

  task automatic load_random_delays();
    for (int c = 0; c < NUM_DELAY_REGS; c++)
      write_reg(REG_DELAY_0 + CFG_IDX_W'(c), pick_delay());
    // A write to an index without a register must change nothing.
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_IDX_W'($urandom_range(NUM_DELAY_REGS, 2 ** CFG_IDX_W - 1)),
                $urandom_range(0, 1) ? DELAY_W'(0) : DELAY_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  initial begin
    int        dz;
    int        n;
    bit        first_pass;
    int        random_start;
    evt_item_t noise;
    tracker = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: all channels off, then a negative timer.
    send_tick();
    send_zero_cross(32767);
    send_tick();
    wait_idle();

    // Zero delay, short delay, off channel and the minimum delay.
    write_reg(REG_DELAY_0, '0);
    write_reg(REG_DELAY_1, DELAY_W'(1));
    write_reg(REG_DELAY_2, OFF_VALUE);
    write_reg(REG_DELAY_3, DELAY_W'(MIN_US));
    write_reg(CFG_IDX_W'(NUM_DELAY_REGS), '0);
    write_reg({CFG_IDX_W{1'b1}}, '0);
    cfg_we <= 1'b0;
    send_zero_cross(0);
    send_ticks(10);
    wait_idle();

    // A new delay only counts from the next zero cross.
    write_reg(REG_DELAY_1, '0);
    cfg_we <= 1'b0;
    send_ticks(85);
    send_zero_cross(3);
    send_ticks(95);
    wait_idle();

    // A run of ticks with no idling on either side.
    send_idle = 1'b0;
    recv_idle = 1'b0;
    write_reg(REG_DELAY_0, OFF_VALUE - 1'b1);
    write_reg(REG_DELAY_1, DELAY_W'(1000));
    write_reg(REG_DELAY_2, '0);
    write_reg(REG_DELAY_3, OFF_VALUE);
    cfg_we <= 1'b0;
    send_zero_cross(0);
    send_ticks(60);
    send_zero_cross(0);
    send_ticks(3);
    wait_idle();

    // Random zero-cross cycles with noise, broken cycles and delay changes.
    first_pass   = 1'b1;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      if (first_pass || $urandom_range(0, 9) < 4) begin
        wait_idle();
        load_random_delays();
      end
      first_pass = 1'b0;
      send_idle  = ($urandom_range(0, 9) < 7);
      recv_idle  = ($urandom_range(0, 9) < 7);
      dz = pick_dz();
      if ($urandom_range(0, 9) != 0) send_zero_cross(dz);
      n = ticks_to_fire(dz) + $urandom_range(0, 15);
      if ($urandom_range(0, 6) == 0) n = $urandom_range(0, n);
      // Keep the total close to the planned item count.
      if (n > RANDOM_ITEMS - (items_sent - random_start))
        n = RANDOM_ITEMS - (items_sent - random_start);
      for (int k = 0; k < n; k++) begin
        if ($urandom_range(0, 49) == 0) begin
          noise.action           = 1'($urandom_range(0, 1));
          noise.delay_until_zero = DZ_W'($urandom);
          send_item(noise);
        end else begin
          send_tick();
        end
        if (k == n / 2 && $urandom_range(0, 6) == 0) begin
          wait_idle();
          load_random_delays();
        end
      end
    end

    wait_idle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
